@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; expect clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Field widths and codes shared by the sprite slot table and its channels.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 9;
    localparam int HANDLE_W = 6;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [POS_W-1:0]    pos_t;

    localparam kind_t KIND_SPAWN = 2'd0;
    localparam kind_t KIND_KILL  = 2'd1;
    localparam kind_t KIND_STEP  = 2'd2;

    localparam status_t ST_SPAWNED     = 3'd0;
    localparam status_t ST_FULL        = 3'd1;
    localparam status_t ST_KILLED      = 3'd2;
    localparam status_t ST_KILL_IGNORE = 3'd3;
    localparam status_t ST_PAIR        = 3'd4;
    localparam status_t ST_DONE        = 3'd5;

endpackage

@@ rtl/sst_cmd_if.sv @@
// ----------------------------------------------------------------------------
// sst_cmd_if
// Valid/ready channel for commands into the slot table.
// ----------------------------------------------------------------------------
interface sst_cmd_if;
    import sst_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    pos_t  x_pos;
    pos_t  y_pos;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, kind, x_pos, y_pos, handle, input ready);
    modport sink   (input valid, kind, x_pos, y_pos, handle, output ready);
endinterface

@@ rtl/sst_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sst_rsp_if
// Valid/ready channel for result items of the slot table.
// ----------------------------------------------------------------------------
interface sst_rsp_if;
    import sst_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    slot_t   slot;
    slot_t   partner_slot;
    logic    last;

    modport source (output valid, status, slot, partner_slot, last, input ready);
    modport sink   (input valid, status, slot, partner_slot, last, output ready);
endinterface

@@ rtl/sprite_slot_table_with_collision.sv @@
// ----------------------------------------------------------------------------
// sprite_slot_table_with_collision
// Sprite slot allocator with a LIFO free stack and same-position collision scan.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transfer: spawn, kill or collision step.
//   rsp returns result items; last marks the final one of a command.
//   Kill: result registered at the accepting edge.
//   Spawn: free stack memory read, then slot write; table full
//   answers at once.
//   Step: one shared position comparator walks slot pairs. An inactive slot
//   is skipped; an active outer slot has its position read and loaded, then
//   each inner slot is skipped if inactive or read and compared if active,
//   and a last pass closes its scan; a colliding pair ends the scan with the
//   second stack push and the pair result in place of the closing pass. The
//   done item follows. The registered position memory read port sets these steps.
//   cmd.ready is high only while no command is in work and the result
//   register is free or being drained; a stalled receiver holds the block.
//   Reset frees all slots and refills the stack at once (a low-water mark
//   stands in for the initial stack contents); there is no clearing pass.
// ----------------------------------------------------------------------------
module sprite_slot_table_with_collision #(
    parameter int SLOTS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    sst_cmd_if.sink   cmd,
    sst_rsp_if.source rsp
);
    import sst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SPAWN     = 3'd1;
    localparam logic [2:0] S_SCAN_I    = 3'd2;
    localparam logic [2:0] S_LOAD_I    = 3'd3;
    localparam logic [2:0] S_SCAN_J    = 3'd4;
    localparam logic [2:0] S_CMP       = 3'd5;
    localparam logic [2:0] S_PUSH_J    = 3'd6;
    localparam logic [2:0] S_EMIT_PAIR = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    top_reg, top_next;
    logic [CW-1:0]    min_top_reg, min_top_next;
    logic [SLOTS-1:0] active_reg, active_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [2*POS_W-1:0] ref_pos_reg, ref_pos_next;
    logic [2*POS_W-1:0] spawn_pos_reg, spawn_pos_next;

    logic [IW-1:0]      stack_mem [SLOTS];
    logic [2*POS_W-1:0] pos_mem   [SLOTS];
    logic [IW-1:0]      stk_rd_reg;
    logic [2*POS_W-1:0] pos_rd_reg;

    logic          stk_we;
    logic [IW-1:0] stk_waddr, stk_wdata;
    logic [CW-1:0] stk_raddr_full;
    logic [IW-1:0] stk_raddr;
    logic          pos_we;
    logic [IW-1:0] pos_waddr, pos_raddr;

    logic          emit_en;
    status_t       emit_status;
    slot_t         emit_slot, emit_partner;
    logic          emit_last;

    logic          rsp_valid_reg;
    status_t       rsp_status_reg;
    slot_t         rsp_slot_reg, rsp_partner_reg;
    logic          rsp_last_reg;

    logic          out_free, cmd_ready, cmd_fire;
    logic [IW-1:0] h_idx, i_idx, j_idx, top_idx, new_slot;
    logic          h_in_range, pop_from_reset;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign cmd_fire  = cmd.valid && cmd_ready;
    assign cmd.ready = cmd_ready;

    assign h_in_range = {{(32-HANDLE_W){1'b0}}, cmd.handle} < 32'(SLOTS);
    assign h_idx      = IW'(cmd.handle);
    assign i_idx      = i_reg[IW-1:0];
    assign j_idx      = j_reg[IW-1:0];
    assign top_idx    = top_reg[IW-1:0];

    // entries below the lowest stack top ever reached were never written; their reset value comes from the index
    assign pop_from_reset = top_reg < min_top_reg;
    assign new_slot       = pop_from_reset ? (IW'(SLOTS - 1) - top_idx) : stk_rd_reg;

    assign stk_raddr_full = top_reg - CW'(1);
    assign stk_raddr      = stk_raddr_full[IW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        min_top_next   = min_top_reg;
        active_next    = active_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ref_pos_next   = ref_pos_reg;
        spawn_pos_next = spawn_pos_reg;
        stk_we         = 1'b0;
        stk_waddr      = top_idx;
        stk_wdata      = '0;
        pos_we         = 1'b0;
        pos_waddr      = top_idx;
        pos_raddr      = '0;
        emit_en        = 1'b0;
        emit_status    = ST_DONE;
        emit_slot      = '0;
        emit_partner   = '0;
        emit_last      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.kind)
                        KIND_SPAWN:
                        begin
                            if (top_reg == CW'(0))
                            begin
                                emit_en     = 1'b1;
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                top_next       = top_reg - CW'(1);
                                spawn_pos_next = {cmd.x_pos, cmd.y_pos};
                                state_next     = S_SPAWN;
                            end
                        end
                        KIND_KILL:
                        begin
                            emit_en = 1'b1;
                            if (h_in_range && active_reg[h_idx])
                            begin
                                active_next[h_idx] = 1'b0;
                                if (top_reg < CW'(SLOTS))
                                begin
                                    stk_we    = 1'b1;
                                    stk_wdata = h_idx;
                                    top_next  = top_reg + CW'(1);
                                end
                                emit_status = ST_KILLED;
                                emit_slot   = SLOT_W'(h_idx);
                            end
                            else
                            begin
                                emit_status = ST_KILL_IGNORE;
                            end
                        end
                        KIND_STEP:
                        begin
                            i_next     = '0;
                            state_next = S_SCAN_I;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SPAWN:
            begin
                // result register is empty here: it was free at the accepting edge
                if (pop_from_reset)
                    min_top_next = top_reg;
                active_next[new_slot] = 1'b1;
                pos_we      = 1'b1;
                pos_waddr   = new_slot;
                emit_en     = 1'b1;
                emit_status = ST_SPAWNED;
                emit_slot   = SLOT_W'(new_slot);
                state_next  = S_IDLE;
            end
            S_SCAN_I:
            begin
                if (i_reg == CW'(SLOTS))
                begin
                    if (out_free)
                    begin
                        emit_en    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (!active_reg[i_idx])
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    pos_raddr  = i_idx;
                    state_next = S_LOAD_I;
                end
            end
            S_LOAD_I:
            begin
                ref_pos_next = pos_rd_reg;
                j_next       = i_reg + CW'(1);
                state_next   = S_SCAN_J;
            end
            S_SCAN_J:
            begin
                if (j_reg == CW'(SLOTS))
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SCAN_I;
                end
                else if (!active_reg[j_idx])
                begin
                    j_next = j_reg + CW'(1);
                end
                else
                begin
                    pos_raddr  = j_idx;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (pos_rd_reg == ref_pos_reg)
                begin
                    active_next[i_idx] = 1'b0;
                    active_next[j_idx] = 1'b0;
                    if (top_reg < CW'(SLOTS))
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = i_idx;
                        top_next  = top_reg + CW'(1);
                    end
                    state_next = S_PUSH_J;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_SCAN_J;
                end
            end
            S_PUSH_J:
            begin
                if (top_reg < CW'(SLOTS))
                begin
                    stk_we    = 1'b1;
                    stk_wdata = j_idx;
                    top_next  = top_reg + CW'(1);
                end
                state_next = S_EMIT_PAIR;
            end
            S_EMIT_PAIR:
            begin
                if (out_free)
                begin
                    emit_en      = 1'b1;
                    emit_status  = ST_PAIR;
                    emit_slot    = SLOT_W'(i_idx);
                    emit_partner = SLOT_W'(j_idx);
                    emit_last    = 1'b0;
                    i_next       = i_reg + CW'(1);
                    state_next   = S_SCAN_I;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= CW'(SLOTS);
            min_top_reg   <= CW'(SLOTS);
            active_reg    <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            min_top_reg <= min_top_next;
            active_reg  <= active_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            if (emit_en)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_pos_reg   <= ref_pos_next;
        spawn_pos_reg <= spawn_pos_next;
        if (emit_en)
        begin
            rsp_status_reg  <= emit_status;
            rsp_slot_reg    <= emit_slot;
            rsp_partner_reg <= emit_partner;
            rsp_last_reg    <= emit_last;
        end
    end

    // free stack memory: one write, one registered read at top - 1
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        stk_rd_reg <= stack_mem[stk_raddr];
    end

    // position memory, {x, y} per slot
    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= spawn_pos_reg;
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.slot         = rsp_slot_reg;
    assign rsp.partner_slot = rsp_partner_reg;
    assign rsp.last         = rsp_last_reg;

endmodule

@@ rtl/sst_checker.sv @@
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks for the sprite slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sst_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cmd_valid,
    input logic                    cmd_ready,
    input logic [sst_pkg::KIND_W-1:0]   cmd_kind,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic [sst_pkg::STATUS_W-1:0] rsp_status,
    input logic [sst_pkg::SLOT_W-1:0]   rsp_slot,
    input logic [sst_pkg::SLOT_W-1:0]   rsp_partner_slot,
    input logic                    rsp_last
);
    import sst_pkg::*;

    logic kill_xfer;
    assign kill_xfer = cmd_valid && cmd_ready && (cmd_kind == KIND_KILL);

    `ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_partner_slot) && $stable(rsp_last), "result changed while stalled")
    `ASSERT_IMP(a_ready_needs_room, cmd_ready, !rsp_valid || rsp_ready, "command taken with result blocked")
    `ASSERT_NXT(a_kill_answer, kill_xfer, rsp_valid && rsp_last && (rsp_status == ST_KILLED || rsp_status == ST_KILL_IGNORE), "kill not answered next cycle")
    `ASSERT_IMP(a_pair_not_last, rsp_valid && (rsp_status == ST_PAIR), !rsp_last, "pair marked last")
    `ASSERT_IMP(a_partner_zero, rsp_valid && (rsp_status != ST_PAIR), rsp_partner_slot == '0, "partner set outside a pair")

endmodule

bind sprite_slot_table_with_collision sst_checker u_sst_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .cmd_kind         (cmd.kind),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_slot         (rsp.slot),
    .rsp_partner_slot (rsp.partner_slot),
    .rsp_last         (rsp.last)
);
